// File: rtl/core/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// Types, codes and constants shared by the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

   localparam logic [2:0] REQ_INIT   = 3'd0;
   localparam logic [2:0] REQ_INSTR  = 3'd1;
   localparam logic [2:0] REQ_CHAR   = 3'd2;
   localparam logic [2:0] REQ_CURSOR = 3'd3;
   localparam logic [2:0] REQ_NUMBER = 3'd4;
   localparam logic [2:0] REQ_HALF   = 3'd5;

   localparam logic [7:0]  STROBE_TICKS_RESET  = 8'd1;
   localparam logic [15:0] POWERUP_TICKS_RESET = 16'd200;

   localparam logic       CSR_STROBE  = 1'b0;
   localparam logic       CSR_POWERUP = 1'b1;

   localparam logic [7:0] CURSOR_BASE = 8'h80;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [3:0] NIB_WAKE    = 4'h3;
   localparam logic [3:0] NIB_FOUR    = 4'h2;

   localparam int          NUM_DIGITS = 10;
   localparam int          BIN_BITS   = 32;
   localparam logic [3:0]  TOP_DIGIT  = 4'(NUM_DIGITS - 1);
   localparam logic [4:0]  LAST_SHIFT = 5'(BIN_BITS - 1);

   localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h0E, 8'h01, 8'h06};

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] payload;
      logic [7:0]  column;
      logic [1:0]  row;
   } req_item_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic [15:0] lead_wait;
      logic [7:0]  gap_after;
      logic        last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      NIB_HI    = 2'd0,
      NIB_LO    = 2'd1,
      NIB_THREE = 2'd2,
      NIB_TWO   = 2'd3
   } nib_sel_type;

   typedef struct packed {
      logic        capture;
      logic        dabble;
      logic        dec_ptr;
      logic        load_init;
      logic [1:0]  init_idx;
      logic        load_digit;
      logic        emit;
      nib_sel_type nib_sel;
      logic        lead;
      logic        gap;
      logic        last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic ptr_zero;
      logic digit_zero;
   } dp_status_type;

endpackage

// File: rtl/core/clns_dpath.sv
// ----------------------------------------------------------------------------
// clns_dpath
// Request capture, binary to decimal shifter, byte assembly and the
// registered strobe output.
// ----------------------------------------------------------------------------
module clns_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  clns_pkg::req_item_type req_data,
   input  logic [7:0]             strobe_ticks,
   input  logic [15:0]            powerup_ticks,
   input  clns_pkg::dp_cmd_type   cmd,
   output clns_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output clns_pkg::rsp_item_type rsp_data
);
   import clns_pkg::*;

   logic                rs_ff, rs_in;
   logic [7:0]          byte_ff, byte_in;
   logic [BIN_BITS-1:0] bin_ff, bin_in;
   logic [4*NUM_DIGITS-1:0] bcd_ff, bcd_in, bcd_adj;
   logic [3:0]          ptr_ff, ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;
   logic [7:0]          cursor_byte;
   logic [3:0]          cur_digit;
   logic [3:0]          nib;

   assign cursor_byte = CURSOR_BASE + req_data.column + {req_data.row, 6'b0};
   assign cur_digit   = bcd_ff[4*ptr_ff +: 4];

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      rs_in   = rs_ff;
      byte_in = byte_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      ptr_in  = ptr_ff;
      if (cmd.capture) begin
         rs_in   = (req_data.req_type == REQ_CHAR) || (req_data.req_type == REQ_NUMBER);
         byte_in = (req_data.req_type == REQ_CURSOR) ? cursor_byte : req_data.payload[7:0];
         bin_in  = req_data.payload;
         bcd_in  = '0;
         ptr_in  = TOP_DIGIT;
      end
      if (cmd.dabble) begin
         bcd_in = {bcd_adj[4*NUM_DIGITS-2:0], bin_ff[BIN_BITS-1]};
         bin_in = {bin_ff[BIN_BITS-2:0], 1'b0};
      end
      if (cmd.dec_ptr) begin
         ptr_in = ptr_ff - 4'd1;
      end
      if (cmd.load_init) begin
         byte_in = INIT_BYTES[cmd.init_idx];
      end
      if (cmd.load_digit) begin
         byte_in = ASCII_ZERO + {4'd0, cur_digit};
      end
   end

   always_comb begin
      case (cmd.nib_sel)
         NIB_HI:    nib = byte_ff[7:4];
         NIB_LO:    nib = byte_ff[3:0];
         NIB_THREE: nib = NIB_WAKE;
         NIB_TWO:   nib = NIB_FOUR;
         default:   nib = byte_ff[7:4];
      endcase
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.ptr_zero   = (ptr_ff == 4'd0);
   assign status.digit_zero = (cur_digit == 4'd0);

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.reg_select = rs_ff;
         rsp_data_in.nibble     = nib;
         rsp_data_in.lead_wait  = cmd.lead ? powerup_ticks : 16'd0;
         rsp_data_in.gap_after  = cmd.gap ? strobe_ticks : 8'd0;
         rsp_data_in.last       = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff       <= rs_in;
      byte_ff     <= byte_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      ptr_ff      <= ptr_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/clns_ctrl.sv
// ----------------------------------------------------------------------------
// clns_ctrl
// Sequencer state machine: walks each request through its strobes and
// drives the datapath commands.
// ----------------------------------------------------------------------------
module clns_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_type,
   input  clns_pkg::dp_status_type status,
   output clns_pkg::dp_cmd_type    cmd
);
   import clns_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_INIT_NIB  = 7'b0000010,
      ST_LOAD_INIT = 7'b0000100,
      ST_BYTE_HI   = 7'b0001000,
      ST_BYTE_LO   = 7'b0010000,
      ST_CONVERT   = 7'b0100000,
      ST_SKIP      = 7'b1000000
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MODE_INIT   = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_HALF   = 2'd3
   } mode_type;

   ctrl_state_type state_ff, state_in;
   mode_type       mode_ff, mode_in;
   logic [4:0]     cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.init_idx = cnt_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_INIT: begin
                     mode_in  = MODE_INIT;
                     state_in = ST_INIT_NIB;
                  end
                  REQ_INSTR, REQ_CHAR, REQ_CURSOR: begin
                     mode_in  = MODE_SINGLE;
                     state_in = ST_BYTE_HI;
                  end
                  REQ_NUMBER: begin
                     mode_in  = MODE_NUMBER;
                     state_in = ST_CONVERT;
                  end
                  REQ_HALF: begin
                     mode_in  = MODE_HALF;
                     state_in = ST_BYTE_HI;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT_NIB: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.nib_sel = (cnt_ff == 5'd3) ? NIB_TWO : NIB_THREE;
               cmd.lead    = (cnt_ff == 5'd0);
               cmd.gap     = 1'b1;
               if (cnt_ff == 5'd3) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD_INIT;
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end
         ST_LOAD_INIT: begin
            cmd.load_init = 1'b1;
            state_in      = ST_BYTE_HI;
         end
         ST_BYTE_HI: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.nib_sel = NIB_HI;
               cmd.gap     = (mode_ff == MODE_HALF);
               cmd.last    = (mode_ff == MODE_HALF);
               state_in    = (mode_ff == MODE_HALF) ? ST_IDLE : ST_BYTE_LO;
            end
         end
         ST_BYTE_LO: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.nib_sel = NIB_LO;
               cmd.gap     = 1'b1;
               case (mode_ff)
                  MODE_INIT: begin
                     cmd.last = (cnt_ff == 5'd3);
                     if (cnt_ff == 5'd3) begin
                        state_in = ST_IDLE;
                     end else begin
                        cnt_in   = cnt_ff + 5'd1;
                        state_in = ST_LOAD_INIT;
                     end
                  end
                  MODE_NUMBER: begin
                     cmd.last = status.ptr_zero;
                     if (status.ptr_zero) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.dec_ptr = 1'b1;
                        state_in    = ST_SKIP;
                     end
                  end
                  default: begin
                     cmd.last = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == LAST_SHIFT) begin
               cnt_in   = '0;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (mode_ff == MODE_NUMBER && cnt_ff == 5'd0 && status.digit_zero
                  && !status.ptr_zero) begin
               cmd.dec_ptr = 1'b1;
            end else begin
               cmd.load_digit = 1'b1;
               cnt_in         = 5'd1;
               state_in       = ST_BYTE_HI;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_INIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/core/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns LCD requests into enable-strobed 4-bit nibble transfers.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_item_type
//   rsp      out        rsp_valid / rsp_stall  rsp_item_type
//   csr      in/out     psel penable pwrite    strobe_ticks, powerup_ticks
//
// one strobe per cycle while rsp is not stalled; init bytes and digits are
// loaded in a state of their own; init sends wake nibbles then four bytes,
// a byte request both nibbles, a half request the high nibble; a number is
// shifted through the binary to decimal shifter, leading zero digits skipped
// a new request is taken only once the previous one has issued its last strobe
// synchronous reset clears the sequencer and output valid and reloads the csrs
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  clns_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output clns_pkg::rsp_item_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import clns_pkg::*;

   logic [7:0]    strobe_ticks_ff, strobe_ticks_in;
   logic [15:0]   powerup_ticks_ff, powerup_ticks_in;
   logic          csr_write;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      strobe_ticks_in  = strobe_ticks_ff;
      powerup_ticks_in = powerup_ticks_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_STROBE:  strobe_ticks_in  = pwdata[7:0];
            CSR_POWERUP: powerup_ticks_in = pwdata[15:0];
            default:     strobe_ticks_in  = strobe_ticks_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_STROBE:  prdata = {24'd0, strobe_ticks_ff};
         CSR_POWERUP: prdata = {16'd0, powerup_ticks_ff};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ticks_ff  <= STROBE_TICKS_RESET;
         powerup_ticks_ff <= POWERUP_TICKS_RESET;
      end else begin
         strobe_ticks_ff  <= strobe_ticks_in;
         powerup_ticks_ff <= powerup_ticks_in;
      end
   end

   clns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_data.req_type),
      .status    (status),
      .cmd       (cmd)
   );

   clns_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .strobe_ticks  (strobe_ticks_ff),
      .powerup_ticks (powerup_ticks_ff),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule
